FILE: rtl/core/tournament_tree_kway_merge_assert.svh
// Assertion macros shared by the merge block.
`ifndef TOURNAMENT_TREE_KWAY_MERGE_ASSERT_SVH
`define TOURNAMENT_TREE_KWAY_MERGE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTKM_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TTKM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ttkm_pkg.sv
`default_nettype none

package ttkm_pkg;

  localparam int unsigned LANES_DEF = 16;
  localparam int unsigned LANE_W    = 4;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned ADDR_LANES = 1 << LANE_W;

  typedef struct packed {
    logic [KEY_W-1:0] ev_time;
    logic [KEY_W-1:0] ev_cell;
    logic [KEY_W-1:0] ev_slot;
    logic [KEY_W-1:0] ev_weight;
  } evt_t;

  localparam evt_t TERM_EV = '{ev_time: '1, ev_cell: '1, ev_slot: '1, ev_weight: '0};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_EMIT
  } state_e;

  // Smallest power of two, at least two, that holds n leaves.
  function automatic int unsigned pow2_ceil(int unsigned n);
    int unsigned l;
    l = 2;
    for (int i = 0; i < 12; i++) begin
      if (l < n) begin
        l = l << 1;
      end
    end
    return l;
  endfunction

  // Rightmost leaf below heap node n of a tree with the given leaf count.
  function automatic int unsigned rightmost_leaf(int unsigned n, int unsigned leaves);
    int unsigned m;
    m = n;
    for (int i = 0; i < 12; i++) begin
      if (m < leaves - 1) begin
        m = 2 * m + 2;
      end
    end
    return m - (leaves - 1);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ttkm_in_if.sv
`default_nettype none

interface ttkm_in_if;
  import ttkm_pkg::*;

  logic              valid;
  logic              ready;
  logic [LANE_W-1:0] lane;
  logic              end_of_lane;
  logic [KEY_W-1:0]  event_time;
  logic [KEY_W-1:0]  target_cell;
  logic [KEY_W-1:0]  target_slot;
  logic [KEY_W-1:0]  weight_bits;

  modport source (
    output valid, lane, end_of_lane, event_time, target_cell, target_slot, weight_bits,
    input  ready
  );

  modport sink (
    input  valid, lane, end_of_lane, event_time, target_cell, target_slot, weight_bits,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/ttkm_out_if.sv
`default_nettype none

interface ttkm_out_if;
  import ttkm_pkg::*;

  logic              valid;
  logic              ready;
  logic [LANE_W-1:0] head_lane;
  logic [KEY_W-1:0]  head_time;
  logic [KEY_W-1:0]  head_cell;
  logic [KEY_W-1:0]  head_slot;
  logic [KEY_W-1:0]  head_weight;
  logic              head_due;
  logic              all_exhausted;

  modport source (
    output valid, head_lane, head_time, head_cell, head_slot, head_weight, head_due,
           all_exhausted,
    input  ready
  );

  modport sink (
    input  valid, head_lane, head_time, head_cell, head_slot, head_weight, head_due,
           all_exhausted,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/ttkm_ram.sv
`default_nettype none

module ttkm_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/core/ttkm_cmp.sv
`default_nettype none

module ttkm_cmp (
  input  wire ttkm_pkg::evt_t a_i,
  input  wire ttkm_pkg::evt_t b_i,
  output logic                before_o
);
  import ttkm_pkg::*;

  // Order by time, then cell, then slot; the weight never takes part.
  always_comb begin
    if (a_i.ev_time != b_i.ev_time) begin
      before_o = a_i.ev_time < b_i.ev_time;
    end else if (a_i.ev_cell != b_i.ev_cell) begin
      before_o = a_i.ev_cell < b_i.ev_cell;
    end else begin
      before_o = a_i.ev_slot < b_i.ev_slot;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/tournament_tree_kway_merge.sv
// Channel   Direction  Handshake      Payload
// cfg       in         cfg_we_i       cfg_wdata_i (horizon)
// in_i      in         valid / ready  lane, end_of_lane, event_time, cell, slot, weight
// out_o     out        valid / ready  head lane and event, head_due, all_exhausted
//
// An item is handled in order: the accept cycle writes the leaf, ST_CMP runs the shared key
// comparator once per tree level (log2(min(leaves, 16)) levels), and ST_EMIT loads the result.
// An item for a lane beyond LANES writes no leaf and goes straight to ST_EMIT.
// Reset marks every stored leaf empty, so empty leaves read as the terminal event.
// The next item is taken while a result waits; the block holds before loading a result
// until the previous one is taken.
`default_nettype none

module tournament_tree_kway_merge #(
  parameter int unsigned LANES = ttkm_pkg::LANES_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [ttkm_pkg::KEY_W-1:0] cfg_wdata_i,
  ttkm_in_if.sink                         in_i,
  ttkm_out_if.source                      out_o
);
  import ttkm_pkg::*;

  localparam int unsigned LEAVES = pow2_ceil(LANES);
  localparam int unsigned WL     = (LEAVES < ADDR_LANES) ? LEAVES : ADDR_LANES;
  localparam int unsigned LW     = $clog2(WL);
  localparam int unsigned NODES  = WL - 1;
  localparam int unsigned IDX_W  = LW + 1;
  localparam bit          CHAIN  = (WL < LEAVES);
  localparam logic [LANE_W-1:0] HEAD_RST = LANE_W'(LEAVES - 1);

  state_e            state_q, state_d;
  logic [KEY_W-1:0]  horizon_q;
  logic [IDX_W-1:0]  idx_q, idx_d;
  evt_t              cand_q, cand_d;
  logic [LW-1:0]     cand_lane_q, cand_lane_d;
  logic [WL-1:0]     valid_q, valid_d;
  logic [LW-1:0]     node_q [NODES];
  logic [LW-1:0]     node_d [NODES];
  evt_t              head_q, head_d;
  logic [LANE_W-1:0] head_lane_q, head_lane_d;
  logic              rd_valid_q;
  logic [LW-1:0]     sib_lane_q;
  logic              out_valid_q, out_valid_d;
  logic              out_load;

  logic              in_accept;
  logic              lane_ok;
  evt_t              new_ev;
  logic [IDX_W-1:0]  parent;
  logic [IDX_W-1:0]  psib;
  logic [LW-1:0]     sibwin;
  logic              ram_we;
  logic [LW-1:0]     ram_raddr;
  evt_t              ram_rdata;
  evt_t              sib_ev;
  evt_t              left_ev, right_ev, win_ev;
  logic [LW-1:0]     win_lane;
  logic              left_before;
  logic              cur_left;
  logic              win_term;

  assign in_accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign lane_ok = (32'(in_i.lane) < LANES);

  always_comb begin
    if (in_i.end_of_lane) begin
      new_ev = TERM_EV;
    end else begin
      new_ev = '{ev_time: in_i.event_time, ev_cell: in_i.target_cell,
                 ev_slot: in_i.target_slot, ev_weight: in_i.weight_bits};
    end
  end

  // Heap walk: the parent of idx and the winner of the parent's sibling subtree.
  assign parent = (idx_q - IDX_W'(1)) >> 1;
  assign psib   = parent[0] ? (parent + IDX_W'(1)) : (parent - IDX_W'(1));
  assign sibwin = (psib >= IDX_W'(NODES)) ? LW'(psib - IDX_W'(NODES)) : node_q[psib[LW-1:0]];

  assign ram_we    = in_accept && lane_ok;
  assign ram_raddr = (state_q == ST_IDLE) ? {in_i.lane[LW-1:1], ~in_i.lane[0]} : sibwin;

  ttkm_ram #(
    .WIDTH ($bits(evt_t)),
    .DEPTH (WL)
  ) u_leaf_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_i.lane[LW-1:0]),
    .wdata_i (new_ev),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign sib_ev   = rd_valid_q ? ram_rdata : TERM_EV;
  assign cur_left = idx_q[0];
  assign left_ev  = cur_left ? cand_q : sib_ev;
  assign right_ev = cur_left ? sib_ev : cand_q;

  ttkm_cmp u_cmp (
    .a_i      (left_ev),
    .b_i      (right_ev),
    .before_o (left_before)
  );

  always_comb begin
    if (left_before == cur_left) begin
      win_ev   = cand_q;
      win_lane = cand_lane_q;
    end else begin
      win_ev   = sib_ev;
      win_lane = sib_lane_q;
    end
  end

  assign win_term = (win_ev.ev_time == '1) && (win_ev.ev_cell == '1) && (win_ev.ev_slot == '1);
  assign out_load = (state_q == ST_EMIT) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cand_d      = cand_q;
    cand_lane_d = cand_lane_q;
    valid_d     = valid_q;
    node_d      = node_q;
    head_d      = head_q;
    head_lane_d = head_lane_q;
    out_valid_d = out_valid_q && !out_o.ready;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (lane_ok) begin
            valid_d[in_i.lane[LW-1:0]] = 1'b1;
            cand_d      = new_ev;
            cand_lane_d = in_i.lane[LW-1:0];
            idx_d       = IDX_W'(NODES) + IDX_W'(in_i.lane[LW-1:0]);
            state_d     = ST_CMP;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_CMP: begin
        node_d[parent[LW-1:0]] = win_lane;
        cand_d      = win_ev;
        cand_lane_d = win_lane;
        idx_d       = parent;
        if (parent == '0) begin
          if (CHAIN && win_term) begin
            head_d      = TERM_EV;
            head_lane_d = HEAD_RST;
          end else begin
            head_d      = win_ev;
            head_lane_d = LANE_W'(win_lane);
          end
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      horizon_q   <= '1;
      valid_q     <= '0;
      head_q      <= TERM_EV;
      head_lane_q <= HEAD_RST;
      out_valid_q <= 1'b0;
      for (int n = 0; n < NODES; n++) begin
        node_q[n] <= LW'(rightmost_leaf(n, WL));
      end
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      head_q      <= head_d;
      head_lane_q <= head_lane_d;
      out_valid_q <= out_valid_d;
      node_q      <= node_d;
      if (cfg_we_i) begin
        horizon_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    cand_q      <= cand_d;
    cand_lane_q <= cand_lane_d;
    rd_valid_q  <= valid_q[ram_raddr];
    sib_lane_q  <= ram_raddr;
    if (out_load) begin
      out_o.head_lane     <= head_lane_q;
      out_o.head_time     <= head_q.ev_time;
      out_o.head_cell     <= head_q.ev_cell;
      out_o.head_slot     <= head_q.ev_slot;
      out_o.head_weight   <= head_q.ev_weight;
      out_o.head_due      <= (head_q.ev_time < horizon_q);
      out_o.all_exhausted <= (head_q.ev_time == '1);
    end
  end

  assign out_o.valid = out_valid_q;

`include "tournament_tree_kway_merge_assert.svh"

  `TTKM_ASSERT_NEXT(a_walk_ends, clk_i, rst_ni, state_q == ST_CMP && parent == '0, state_q == ST_EMIT, "root update did not lead to result load")
  `TTKM_ASSERT_NEXT(a_skip_lane, clk_i, rst_ni, in_accept && !lane_ok, state_q == ST_EMIT, "item for an absent lane did not go straight to result")
  `TTKM_ASSERT_IMPL(a_exhausted_not_due, clk_i, rst_ni, out_o.valid && out_o.all_exhausted, !out_o.head_due, "terminal head reported as due")

endmodule

`default_nettype wire

FILE: dv/tb_tournament_tree_kway_merge.sv
`timescale 1ns / 1ps

module tb_tournament_tree_kway_merge;
  import ttkm_pkg::*;

  localparam int unsigned LEAVES = 16;
  localparam int unsigned NODES = LEAVES - 1;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS = 230;

  typedef struct packed {
    logic [LANE_W-1:0] lane;
    logic              eol;
    evt_t              ev;
  } lane_write_t;

  typedef struct packed {
    logic [LANE_W-1:0] lane;
    evt_t              ev;
    logic              due;
    logic              exhausted;
  } head_t;

  class merge_head_model;
    logic [KEY_W-1:0]  horizon;
    evt_t              leaf[LEAVES];
    logic [LANE_W-1:0] node_win[NODES];
    head_t             expected_heads[$];
    int unsigned       errors;

    function new();
      horizon = '1;
      errors = 0;
      foreach (leaf[i]) leaf[i] = TERM_EV;
      for (int p = NODES - 1; p >= 0; p--) settle(p);
    endfunction

    function bit orders_first(int unsigned a, int unsigned b);
      if (leaf[a].ev_time != leaf[b].ev_time) return leaf[a].ev_time < leaf[b].ev_time;
      if (leaf[a].ev_cell != leaf[b].ev_cell) return leaf[a].ev_cell < leaf[b].ev_cell;
      return leaf[a].ev_slot < leaf[b].ev_slot;
    endfunction

    function int unsigned winner_of(int unsigned pos);
      if (pos >= NODES) return pos - NODES;
      return node_win[pos];
    endfunction

    function void settle(int unsigned p);
      int unsigned lw;
      int unsigned rw;
      lw = winner_of(2 * p + 1);
      rw = winner_of(2 * p + 2);
      node_win[p] = orders_first(lw, rw) ? LANE_W'(lw) : LANE_W'(rw);
    endfunction

    function void take_write(lane_write_t w);
      int unsigned q;
      head_t h;
      leaf[w.lane] = w.eol ? TERM_EV : w.ev;
      q = NODES + w.lane;
      while (q > 0) begin
        q = (q - 1) >> 1;
        settle(q);
      end
      h.lane = node_win[0];
      h.ev = leaf[node_win[0]];
      h.due = h.ev.ev_time < horizon;
      h.exhausted = h.ev.ev_time == '1;
      expected_heads.insert(expected_heads.size(), h);
    endfunction

    function void check_head(head_t got);
      head_t want;
      if (expected_heads.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("head item with none expected: lane %0d time %h", got.lane,
                   got.ev.ev_time);
        end
        return;
      end
      want = expected_heads.pop_front();
      if (got.lane !== want.lane || got.ev.ev_time !== want.ev.ev_time ||
          got.ev.ev_cell !== want.ev.ev_cell || got.ev.ev_slot !== want.ev.ev_slot ||
          got.ev.ev_weight !== want.ev.ev_weight || got.due !== want.due ||
          got.exhausted !== want.exhausted) begin
        errors++;
        if (errors <= 10) begin
          $display("head item error: exp lane %0d t %h c %h s %h w %h due %b ex %b",
                   want.lane, want.ev.ev_time, want.ev.ev_cell, want.ev.ev_slot,
                   want.ev.ev_weight, want.due, want.exhausted);
          $display("                 got lane %0d t %h c %h s %h w %h due %b ex %b",
                   got.lane, got.ev.ev_time, got.ev.ev_cell, got.ev.ev_slot,
                   got.ev.ev_weight, got.due, got.exhausted);
        end
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [KEY_W-1:0] cfg_wdata_i;
  logic             hold_request;

  ttkm_in_if  in_ch ();
  ttkm_out_if out_ch ();

  merge_head_model heads;

  tournament_tree_kway_merge u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("tournament_tree_kway_merge: mismatch");
    $finish;
  end

  always @(posedge clk_i) begin : monitor
    head_t       got;
    lane_write_t w;
    if (rst_ni) begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.lane = out_ch.head_lane;
        got.ev.ev_time = out_ch.head_time;
        got.ev.ev_cell = out_ch.head_cell;
        got.ev.ev_slot = out_ch.head_slot;
        got.ev.ev_weight = out_ch.head_weight;
        got.due = out_ch.head_due;
        got.exhausted = out_ch.all_exhausted;
        heads.check_head(got);
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        w.lane = in_ch.lane;
        w.eol = in_ch.end_of_lane;
        w.ev.ev_time = in_ch.event_time;
        w.ev.ev_cell = in_ch.target_cell;
        w.ev.ev_slot = in_ch.target_slot;
        w.ev.ev_weight = in_ch.weight_bits;
        heads.take_write(w);
      end
    end
  end

  initial begin : receiver
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= ($urandom_range(0, 4) != 0);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic lane_write_t make_write(input int unsigned lane, input bit eol,
                                             input logic [KEY_W-1:0] t,
                                             input logic [KEY_W-1:0] c,
                                             input logic [KEY_W-1:0] s,
                                             input logic [KEY_W-1:0] wt);
    lane_write_t w;
    w.lane = LANE_W'(lane);
    w.eol = eol;
    w.ev.ev_time = t;
    w.ev.ev_cell = c;
    w.ev.ev_slot = s;
    w.ev.ev_weight = wt;
    return w;
  endfunction

  function automatic logic [KEY_W-1:0] pick_time(input logic [KEY_W-1:0] hz);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return KEY_W'($urandom_range(0, 15));
      4, 5, 6: return hz + KEY_W'($urandom_range(0, 6)) - KEY_W'(3);
      7, 8: return KEY_W'($urandom);
      default: return '1;
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] pick_sub_key();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return KEY_W'($urandom_range(0, 3));
      6, 7, 8: return KEY_W'($urandom);
      default: return '1;
    endcase
  endfunction

  function automatic lane_write_t random_write(input logic [KEY_W-1:0] hz);
    return make_write($urandom_range(0, LEAVES - 1), $urandom_range(0, 9) == 0,
                      pick_time(hz), pick_sub_key(), pick_sub_key(), KEY_W'($urandom));
  endfunction

  task automatic send_stream(input lane_write_t items[$]);
    int unsigned burst;
    burst = 0;
    foreach (items[i]) begin
      if (burst == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      end
      in_ch.valid <= 1'b1;
      in_ch.lane <= items[i].lane;
      in_ch.end_of_lane <= items[i].eol;
      in_ch.event_time <= items[i].ev.ev_time;
      in_ch.target_cell <= items[i].ev.ev_cell;
      in_ch.target_slot <= items[i].ev.ev_slot;
      in_ch.weight_bits <= items[i].ev.ev_weight;
      @(posedge clk_i);
      while (in_ch.ready !== 1'b1) @(posedge clk_i);
      burst--;
    end
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (heads.expected_heads.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_horizon(input logic [KEY_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    heads.horizon = value;
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned count);
    lane_write_t items[$];
    lane_write_t w;
    int unsigned order[LEAVES];
    int unsigned j;
    int unsigned tmp;
    for (int unsigned n = 0; n < count; n++) begin
      items.insert(items.size(), random_write(heads.horizon));
    end
    // Every phase ends by retiring all lanes in a random order.
    foreach (order[i]) order[i] = i;
    for (int i = LEAVES - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    foreach (order[i]) begin
      w = random_write(heads.horizon);
      w.lane = LANE_W'(order[i]);
      w.eol = 1'b1;
      items.insert(items.size(), w);
    end
    send_stream(items);
    wait_drained();
  endtask

  initial begin : stimulus
    lane_write_t directed[$];
    heads = new();
    hold_request = 1'b0;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    in_ch.valid <= 1'b0;
    in_ch.lane <= '0;
    in_ch.end_of_lane <= 1'b0;
    in_ch.event_time <= '0;
    in_ch.target_cell <= '0;
    in_ch.target_slot <= '0;
    in_ch.weight_bits <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    directed.insert(directed.size(), make_write(0, 0, 10, 10, 10, '0));
    directed.insert(directed.size(), make_write(15, 0, 10, 10, 10, '1));
    directed.insert(directed.size(), make_write(8, 0, 10, 10, 9, 32'h1234_5678));
    directed.insert(directed.size(), make_write(9, 0, 10, 9, '1, 32'h8765_4321));
    directed.insert(directed.size(), make_write(1, 0, 9, '1, '1, 32'hdead_beef));
    directed.insert(directed.size(), make_write(1, 1, 0, 0, 0, 32'h5555_5555));
    directed.insert(directed.size(), make_write(2, 0, 0, 0, 0, 32'ha5a5_a5a5));
    directed.insert(directed.size(), make_write(14, 0, 0, 0, 0, 32'h5a5a_5a5a));
    directed.insert(directed.size(), make_write(14, 1, '1, '1, '1, '1));
    directed.insert(directed.size(), make_write(2, 1, 0, 0, 0, 0));
    directed.insert(directed.size(), make_write(9, 1, 0, 0, 0, 0));
    directed.insert(directed.size(), make_write(8, 1, 0, 0, 0, 0));
    directed.insert(directed.size(), make_write(0, 1, 0, 0, 0, 0));
    directed.insert(directed.size(), make_write(15, 1, 0, 0, 0, 0));
    directed.insert(directed.size(), make_write(6, 0, '1, 0, 0, 32'h0000_0001));
    directed.insert(directed.size(), make_write(6, 0, '1, '1, '1, 32'h0000_1234));
    directed.insert(directed.size(), make_write(3, 0, 32'hffff_fffe, '1, '1, 32'hffff_0000));
    directed.insert(directed.size(), make_write(3, 1, 0, 0, 0, 32'h0000_ffff));
    directed.insert(directed.size(), make_write(6, 1, 0, 0, 0, 0));
    send_stream(directed);
    wait_drained();

    write_horizon('0);
    run_phase(PHASE_ITEMS);
    write_horizon(KEY_W'($urandom));
    hold_request = 1'b1;
    run_phase(PHASE_ITEMS);
    write_horizon('1);
    run_phase(PHASE_ITEMS);
    write_horizon(KEY_W'(8));
    run_phase(PHASE_ITEMS);
    write_horizon(KEY_W'($urandom));
    run_phase(PHASE_ITEMS);

    if (heads.errors == 0 && heads.expected_heads.size() == 0) begin
      $display("tournament_tree_kway_merge: match");
    end else begin
      $display("tournament_tree_kway_merge: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/ttkm_pkg.sv
rtl/core/ttkm_in_if.sv
rtl/core/ttkm_out_if.sv
rtl/core/ttkm_ram.sv
rtl/core/ttkm_cmp.sv
rtl/core/tournament_tree_kway_merge.sv
dv/tb_tournament_tree_kway_merge.sv
